>>> src/hpq_pkg.sv
// Shared types and codes of the max-heap priority queue.
package hpq_pkg;

   // Request kinds carried on req_tuser
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // One heap entry, priority in the lowest bits
   typedef struct packed {
      logic [11:0] job_pages;
      logic [15:0] job_num;
      logic [7:0]  job_prio;
   } entry_type;

   // Request beat payload
   typedef struct packed {
      logic [3:0] pad;
      entry_type  entry;
   } req_data_type;

   // Result beat payload
   typedef struct packed {
      logic [2:0]  pad;
      logic [1:0]  op_status;
      logic [5:0]  entry_count;
      logic [11:0] top_pages;
      logic [15:0] top_job_number;
      logic [7:0]  top_priority;
      logic        top_valid;
   } rsp_data_type;

endpackage

>>> src/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: stream ports, root copy, result register.
// Sequencing: a flagged op or an insert into an empty heap goes straight to the result; an
//   insert into a non-empty heap or a remove walks the store one level a cycle first.
// Throughput: one item at a time; the next request beat is taken once the current result
//   is in the output register.
// Reset: synchronous, active high; empties the heap (count zero) and drops a pending
//   result. The entry store needs no clearing pass.
module max_heap_priority_queue #(
   parameter int HEAP_DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hpq_pkg::REQ_DATA_W-1:0]   req_tdata,  // job_priority[7:0],
                                                        // job_number[23:8], job_pages[35:24]
   input  logic                             req_tuser,  // req_type[0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hpq_pkg::RSP_DATA_W-1:0]   rsp_tdata   // top_valid[0], top_priority[8:1],
                                                        // top_job_number[24:9],
                                                        // top_pages[36:25],
                                                        // entry_count[42:37],
                                                        // op_status[44:43]
);
   import hpq_pkg::*;

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);

   req_data_type   req_data;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   entry_type      wr_data;
   logic [AW-1:0]  rd_addr_a;
   logic [AW-1:0]  rd_addr_b;
   entry_type      rd_data_a;
   entry_type      rd_data_b;
   logic           res_valid;
   logic           res_ready;
   logic [CW-1:0]  res_count;
   logic [1:0]     res_status;
   entry_type      root_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_data_type   rsp_data_ff, rsp_data_in;

   assign req_data = req_data_type'(req_tdata);

   hpq_mem #(
      .DEPTH (HEAP_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   hpq_engine #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .AW         (AW),
      .CW         (CW)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_entry  (req_data.entry),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_count  (res_count),
      .res_status (res_status)
   );

   // Keep a copy of the root entry by watching writes to slot zero
   always_ff @(posedge clock) begin
      if (wr_en && wr_addr == '0) begin
         root_ff <= wr_data;
      end
   end

   assign res_ready = !rsp_valid_ff || rsp_tready;

   // Build the result beat
   always_comb begin
      rsp_data_in                = '0;
      rsp_data_in.op_status      = res_status;
      rsp_data_in.entry_count    = 6'(res_count);
      if (res_count != '0) begin
         rsp_data_in.top_valid      = 1'b1;
         rsp_data_in.top_priority   = root_ff.job_prio;
         rsp_data_in.top_job_number = root_ff.job_num;
         rsp_data_in.top_pages      = root_ff.job_pages;
      end
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold the result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

endmodule

>>> src/hpq_mem.sv
// Heap entry store: one write port, two registered read ports.
module hpq_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  hpq_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output hpq_pkg::entry_type  rd_data_a,
   output hpq_pkg::entry_type  rd_data_b
);
   import hpq_pkg::*;

   entry_type store_ff [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   // Write one entry, read two
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_ff[rd_addr_a];
      rd_b_ff <= store_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> src/hpq_engine.sv
// Sift-up / sift-down sequencer that walks the heap store one level a cycle.
module hpq_engine #(
   parameter int HEAP_DEPTH = 32,
   parameter int AW         = 5,
   parameter int CW         = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  hpq_pkg::entry_type  req_entry,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output hpq_pkg::entry_type  wr_data,
   output logic [AW-1:0]       rd_addr_a,
   output logic [AW-1:0]       rd_addr_b,
   input  hpq_pkg::entry_type  rd_data_a,
   input  hpq_pkg::entry_type  rd_data_b,
   output logic                res_valid,
   input  logic                res_ready,
   output logic [CW-1:0]       res_count,
   output logic [1:0]          res_status
);
   import hpq_pkg::*;

   localparam int IW = AW + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST,
      ST_UP,
      ST_DOWN,
      ST_DONE
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   pos_ff, pos_in;
   entry_type       item_ff, item_in;
   logic [1:0]      status_ff, status_in;

   logic [AW-1:0]   par_idx;
   logic [AW-1:0]   gpar_idx;
   logic [IW-1:0]   left_idx;
   logic [IW-1:0]   right_idx;
   logic [IW-1:0]   count_ext;
   logic            left_wins;
   logic            right_wins;
   logic [7:0]      best_prio;
   logic [AW-1:0]   best_idx;
   entry_type       best_entry;
   logic [IW-1:0]   best_left;
   logic            accept;

   // Heap index arithmetic
   always_comb begin
      par_idx   = AW'((pos_ff - 1'b1) >> 1);
      gpar_idx  = AW'((par_idx - 1'b1) >> 1);
      left_idx  = IW'({pos_ff, 1'b1});
      right_idx = left_idx + 1'b1;
      count_ext = IW'(count_ff);
   end

   // Pick the larger child; left wins a tie, child must be strictly greater
   always_comb begin
      left_wins  = (left_idx < count_ext) && (rd_data_a.job_prio > item_ff.job_prio);
      best_prio  = left_wins ? rd_data_a.job_prio : item_ff.job_prio;
      right_wins = (right_idx < count_ext) && (rd_data_b.job_prio > best_prio);
      if (right_wins) begin
         best_idx   = AW'(right_idx);
         best_entry = rd_data_b;
      end else begin
         best_idx   = AW'(left_idx);
         best_entry = rd_data_a;
      end
      best_left = IW'({best_idx, 1'b1});
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Sequence one item through the store
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      item_in   = item_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = item_ff;
      rd_addr_a = par_idx;
      rd_addr_b = AW'(right_idx);
      res_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = STATUS_DONE;
               item_in   = req_entry;
               if (req_kind == REQ_INSERT) begin
                  if (count_ext >= IW'(HEAP_DEPTH)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = req_entry;
                     count_in = CW'(1);
                     state_in = ST_DONE;
                  end else begin
                     pos_in    = AW'(count_ff);
                     rd_addr_a = AW'((count_ff - 1'b1) >> 1);
                     state_in  = ST_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     rd_addr_a = AW'(count_ff - 1'b1);
                     count_in  = count_ff - 1'b1;
                     pos_in    = '0;
                     state_in  = ST_LAST;
                  end
               end
            end
         end
         ST_LAST: begin
            // Last entry becomes the one to sift down from the root
            item_in   = rd_data_a;
            rd_addr_a = AW'(1);
            rd_addr_b = AW'(2);
            state_in  = (count_ff == '0) ? ST_DONE : ST_DOWN;
         end
         ST_UP: begin
            wr_en = 1'b1;
            if (pos_ff != '0 && rd_data_a.job_prio < item_ff.job_prio) begin
               // Move the parent down into the hole
               wr_data   = rd_data_a;
               pos_in    = par_idx;
               rd_addr_a = gpar_idx;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DOWN: begin
            wr_en = 1'b1;
            if (left_wins || right_wins) begin
               // Move the winning child up into the hole
               wr_data   = best_entry;
               pos_in    = best_idx;
               rd_addr_a = AW'(best_left);
               rd_addr_b = AW'(best_left + 1'b1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      item_ff   <= item_in;
      status_ff <= status_in;
   end

   assign res_count  = count_ff;
   assign res_status = status_ff;

   // Count never passes the store depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HEAP_DEPTH))
      else $error("heap count beyond depth");

   // During sift-down the hole lies inside the held entries
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DOWN) |-> (IW'(pos_ff) < count_ext))
      else $error("sift-down hole outside heap");

   // During sift-up the hole is at most the next free slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UP) |-> (IW'(pos_ff) <= count_ext))
      else $error("sift-up hole outside heap");

   // A write only lands inside the store
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (IW'(wr_addr) < IW'(HEAP_DEPTH)))
      else $error("store write out of range");

endmodule

>>> tb/max_heap_priority_queue_test.sv
// Self-checking testbench for the max-heap priority queue with stream ports.
`timescale 1ns / 100ps

module max_heap_priority_queue_test;
   import hpq_pkg::*;

   localparam int HEAP_DEPTH   = 32;
   localparam int RANDOM_ITEMS = 1700;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   typedef enum int {RUN_FILL, RUN_DRAIN, RUN_MIXED} run_kind_type;

   // One directed request; want is used only when check_typed is set
   typedef struct {
      logic         kind;
      entry_type    ent;
      bit           check_typed;
      rsp_data_type want;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // job_priority[7:0], job_number[23:8], job_pages[35:24]
   logic        req_tuser;   // req_type[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // top_valid[0], top_priority[8:1], top_job_number[24:9],
                             // top_pages[36:25], entry_count[42:37], op_status[44:43]

   // Shadow heap and expected tops
   entry_type        shadow_heap [HEAP_DEPTH];
   int               shadow_count;
   rsp_data_type     pending_tops [$];
   directed_row_type directed_rows [$];

   int requests_sent;
   int results_seen;
   int mismatch_count;
   int full_drops;
   int empty_removes;
   int peak_fill;

   bit send_idle;
   bit recv_idle;

   max_heap_priority_queue #(
      .HEAP_DEPTH(HEAP_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Bound the run
   initial begin
      #5ms;
      $display("timeout: %0d requests sent, %0d results seen", requests_sent, results_seen);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic entry_type job(input logic [7:0] prio, input logic [15:0] num,
                                     input logic [11:0] pages);
      entry_type e;
      e.job_pages = pages;
      e.job_num   = num;
      e.job_prio  = prio;
      return e;
   endfunction

   function automatic rsp_data_type top_of(input logic valid, input logic [7:0] prio,
                                           input logic [15:0] num, input logic [11:0] pages,
                                           input logic [5:0] count, input logic [1:0] status);
      rsp_data_type r;
      r                = '0;
      r.top_valid      = valid;
      r.top_priority   = prio;
      r.top_job_number = num;
      r.top_pages      = pages;
      r.entry_count    = count;
      r.op_status      = status;
      return r;
   endfunction

   // Apply one request to the shadow heap and return the top it leaves
   function automatic rsp_data_type heap_top_after(input logic kind, input entry_type ent);
      int           pos;
      int           par;
      int           lc;
      int           rc;
      int           best;
      entry_type    tmp;
      rsp_data_type r;
      r = '0;
      r.op_status = STATUS_DONE;
      if (kind == REQ_INSERT) begin
         if (shadow_count < HEAP_DEPTH) begin
            // sift up while the parent is strictly lower
            pos = shadow_count;
            while (pos > 0) begin
               par = (pos - 1) / 2;
               if (shadow_heap[par].job_prio >= ent.job_prio) break;
               shadow_heap[pos] = shadow_heap[par];
               pos = par;
            end
            shadow_heap[pos] = ent;
            shadow_count++;
         end else begin
            r.op_status = STATUS_FULL;
            full_drops++;
         end
      end else begin
         if (shadow_count > 0) begin
            shadow_heap[0] = shadow_heap[shadow_count - 1];
            shadow_count--;
            // sift down; left child wins a tie
            pos = 0;
            forever begin
               lc   = 2 * pos + 1;
               rc   = 2 * pos + 2;
               best = pos;
               if (lc < shadow_count && shadow_heap[lc].job_prio > shadow_heap[best].job_prio)
                  best = lc;
               if (rc < shadow_count && shadow_heap[rc].job_prio > shadow_heap[best].job_prio)
                  best = rc;
               if (best == pos) break;
               tmp               = shadow_heap[pos];
               shadow_heap[pos]  = shadow_heap[best];
               shadow_heap[best] = tmp;
               pos               = best;
            end
         end else begin
            r.op_status = STATUS_EMPTY;
            empty_removes++;
         end
      end
      if (shadow_count > peak_fill) peak_fill = shadow_count;
      if (shadow_count > 0) begin
         r.top_valid      = 1'b1;
         r.top_priority   = shadow_heap[0].job_prio;
         r.top_job_number = shadow_heap[0].job_num;
         r.top_pages      = shadow_heap[0].job_pages;
      end
      r.entry_count = 6'(shadow_count);
      return r;
   endfunction

   task automatic add_row(input logic kind, input entry_type ent, input bit check_typed,
                          input rsp_data_type want);
      directed_row_type row;
      row.kind        = kind;
      row.ent         = ent;
      row.check_typed = check_typed;
      row.want        = want;
      directed_rows.push_back(row);
   endtask

   // Offer one request beat after a random gap and record its expected top
   task automatic send_request(input logic kind, input entry_type ent, input bit check_typed,
                               input rsp_data_type want);
      int           gap;
      rsp_data_type predicted;
      if (requests_sent % 100 == 0)
         send_idle = ($urandom_range(0, 3) != 0);
      gap = send_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, ent};
      do @(posedge clock); while (!req_tready);
      predicted = heap_top_after(kind, ent);
      pending_tops.push_back(check_typed ? want : predicted);
      requests_sent++;
   endtask

   // Stimulus
   initial begin : stimulus
      run_kind_type run_mode;
      int           run_len;
      int           sel;
      logic         kind;
      logic [7:0]   prio;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = REQ_INSERT;
      shadow_count  = 0;
      requests_sent = 0;
      full_drops    = 0;
      empty_removes = 0;
      peak_fill     = 0;
      send_idle     = 1'b1;

      // empty, extremes and ties
      add_row(REQ_REMOVE, job(8'h00, 16'h0000, 12'h000), 1,
              top_of(1'b0, 8'h00, 16'h0000, 12'h000, 6'd0, STATUS_EMPTY));
      add_row(REQ_INSERT, job(8'hff, 16'hffff, 12'hfff), 1,
              top_of(1'b1, 8'hff, 16'hffff, 12'hfff, 6'd1, STATUS_DONE));
      add_row(REQ_INSERT, job(8'h00, 16'h0000, 12'h000), 1,
              top_of(1'b1, 8'hff, 16'hffff, 12'hfff, 6'd2, STATUS_DONE));
      // equal priority must not displace the older root
      add_row(REQ_INSERT, job(8'hff, 16'h1234, 12'h001), 1,
              top_of(1'b1, 8'hff, 16'hffff, 12'hfff, 6'd3, STATUS_DONE));
      add_row(REQ_INSERT, job(8'h80, 16'haaaa, 12'h555), 0, '0);
      add_row(REQ_INSERT, job(8'h80, 16'h5555, 12'haaa), 0, '0);
      repeat (4) add_row(REQ_REMOVE, job(8'h00, 16'h0000, 12'h000), 0, '0);
      add_row(REQ_REMOVE, job(8'h00, 16'h0000, 12'h000), 1,
              top_of(1'b0, 8'h00, 16'h0000, 12'h000, 6'd0, STATUS_DONE));
      // payload on a remove is ignored
      add_row(REQ_REMOVE, job(8'hff, 16'hffff, 12'hfff), 1,
              top_of(1'b0, 8'h00, 16'h0000, 12'h000, 6'd0, STATUS_EMPTY));
      // children tie on sift down
      add_row(REQ_INSERT, job(8'd10, 16'h0010, 12'h010), 0, '0);
      add_row(REQ_INSERT, job(8'd20, 16'h0020, 12'h020), 0, '0);
      add_row(REQ_INSERT, job(8'd20, 16'h0021, 12'h021), 0, '0);
      add_row(REQ_REMOVE, job(8'h00, 16'h0000, 12'h000), 0, '0);
      add_row(REQ_INSERT, job(8'd20, 16'h0022, 12'h022), 0, '0);
      add_row(REQ_INSERT, job(8'd30, 16'h0030, 12'h030), 0, '0);
      repeat (4) add_row(REQ_REMOVE, job(8'h00, 16'h0000, 12'h000), 0, '0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].kind, directed_rows[i].ent,
                      directed_rows[i].check_typed, directed_rows[i].want);

      // Random runs: fill past full, drain past empty, or mix
      while (requests_sent < RANDOM_ITEMS + directed_rows.size()) begin
         run_mode = run_kind_type'($urandom_range(0, 2));
         run_len  = $urandom_range(8, 48);
         repeat (run_len) begin
            unique case (run_mode)
               RUN_FILL:  kind = ($urandom_range(0, 7) == 0) ? REQ_REMOVE : REQ_INSERT;
               RUN_DRAIN: kind = ($urandom_range(0, 7) == 0) ? REQ_INSERT : REQ_REMOVE;
               default:   kind = ($urandom_range(0, 1) == 0) ? REQ_INSERT : REQ_REMOVE;
            endcase
            sel = $urandom_range(0, 9);
            if (sel == 0)
               prio = 8'h00;
            else if (sel == 1)
               prio = 8'hff;
            else if (sel < 4)
               prio = 8'($urandom_range(0, 3));
            else
               prio = 8'($urandom_range(0, 255));
            send_request(kind, job(prio, 16'($urandom_range(0, 65535)),
                                   12'($urandom_range(0, 4095))), 0, '0);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Wait out the remaining results
      while (pending_tops.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results for %0d requests, heap filled up to %0d entries.",
               results_seen, requests_sent, peak_fill);
      $display("Saw %0d inserts dropped on a full heap and %0d removes on an empty heap.",
               full_drops, empty_removes);
      if (mismatch_count == 0 && pending_tops.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result consumer: random stalls plus two long hold-offs to back up the input
   initial begin : consumer
      int stall;
      int beats;
      rsp_tready = 1'b0;
      recv_idle  = 1'b1;
      beats      = 0;
      while (reset) @(negedge clock);
      forever begin
         if (beats % 80 == 0)
            recv_idle = ($urandom_range(0, 3) != 0);
         stall = recv_idle ? $urandom_range(0, 15) : 0;
         if (beats == 300 || beats == 1100)
            stall = HOLD_CYCLES;
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         beats++;
      end
   end

   // Compare each result beat with the oldest expected top
   rsp_data_type got;
   rsp_data_type want;

   initial begin
      results_seen   = 0;
      mismatch_count = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (pending_tops.size() == 0) begin
            $error("result beat with no request outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_tops.pop_front();
            if (got.top_valid !== want.top_valid) begin
               $error("top_valid: expected %0d, got %0d", want.top_valid, got.top_valid);
               mismatch_count++;
            end
            if (got.top_priority !== want.top_priority) begin
               $error("top_priority: expected %0d, got %0d",
                      want.top_priority, got.top_priority);
               mismatch_count++;
            end
            if (got.top_job_number !== want.top_job_number) begin
               $error("top_job_number: expected %0d, got %0d",
                      want.top_job_number, got.top_job_number);
               mismatch_count++;
            end
            if (got.top_pages !== want.top_pages) begin
               $error("top_pages: expected %0d, got %0d", want.top_pages, got.top_pages);
               mismatch_count++;
            end
            if (got.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
               mismatch_count++;
            end
            if (got.op_status !== want.op_status) begin
               $error("op_status: expected %0d, got %0d", want.op_status, got.op_status);
               mismatch_count++;
            end
         end
      end
   end

endmodule
